### rtl/qte_pkg.sv
package qte_pkg;

   // Number of CORDIC vectoring steps per angle (8 to 24).
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

   // CORDIC datapath widths.
   localparam int VEC_W   = 40;
   localparam int ANGLE_W = 36;

   // Square root unit: radicand and root widths.
   localparam int RAD_W  = 58;
   localparam int ROOT_W = RAD_W / 2;

   // Pi in Q.32 radians.
   localparam logic signed [ANGLE_W-1:0] PI_Q32 = 36'sd13493037705;

   // Angle limits in Q3.12 radians.
   localparam logic [15:0] PI_Q12  = 16'd12868;
   localparam logic [15:0] HPI_Q12 = 16'd6434;

   // Stillness threshold after reset.
   localparam logic [15:0] STILL_RESET = 16'd3;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_SUM,
      ST_PSQ,
      ST_PCROOT,
      ST_ROLL,
      ST_PITCH,
      ST_YAW,
      ST_GRAV,
      ST_DONE
   } seq_state_type;

   // Arctangent of 2^-i in Q.32 radians.
   function automatic logic signed [ANGLE_W-1:0] atan_q32(input logic [4:0] i);
      logic signed [ANGLE_W-1:0] a;
      case (i)
         5'd0:    a = 36'sd3373259426;
         5'd1:    a = 36'sd1991351318;
         5'd2:    a = 36'sd1052175346;
         5'd3:    a = 36'sd534100635;
         5'd4:    a = 36'sd268086748;
         5'd5:    a = 36'sd134174063;
         5'd6:    a = 36'sd67103403;
         5'd7:    a = 36'sd33553749;
         5'd8:    a = 36'sd16777131;
         5'd9:    a = 36'sd8388597;
         5'd10:   a = 36'sd4194303;
         default: a = ANGLE_W'(36'sd1 <<< (6'd32 - {1'b0, i}));
      endcase
      return a;
   endfunction

endpackage

### rtl/qte_isqrt.sv
// Floor square root, one result bit per cycle, with the remainder n - r*r.
module qte_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [qte_pkg::RAD_W-1:0] radicand,
   output logic                      done,
   output logic [qte_pkg::ROOT_W-1:0] root,
   output logic [qte_pkg::ROOT_W+1:0] remainder
);

   localparam int REM_W = qte_pkg::ROOT_W + 3;
   localparam int CNT_W = $clog2(qte_pkg::ROOT_W + 1);

   logic [qte_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [qte_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [REM_W-1:0]           rem_shift;
   logic [REM_W-1:0]           trial;

   // One digit step: bring down two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], rad_ff[qte_pkg::RAD_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = {rad_ff[qte_pkg::RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[qte_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[qte_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(qte_pkg::ROOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done      = done_ff;
   assign root      = root_ff;
   assign remainder = rem_ff[qte_pkg::ROOT_W+1:0];

endmodule

### rtl/qte_cordic.sv
// CORDIC vectoring: angle of (x, y) in Q.32 radians, one rotation per cycle.
module qte_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [qte_pkg::VEC_W-1:0]   y_in,
   input  logic signed [qte_pkg::VEC_W-1:0]   x_in,
   output logic                               done,
   output logic signed [qte_pkg::ANGLE_W-1:0] angle
);

   logic signed [qte_pkg::VEC_W-1:0]   x_ff, x_in_n;
   logic signed [qte_pkg::VEC_W-1:0]   y_ff, y_in_n;
   logic signed [qte_pkg::ANGLE_W-1:0] z_ff, z_in;
   logic [qte_pkg::STEP_W-1:0]         i_ff, i_in;
   logic                               run_ff, run_in;
   logic                               done_ff, done_in;
   logic signed [qte_pkg::VEC_W-1:0]   xs;
   logic signed [qte_pkg::VEC_W-1:0]   ys;
   logic signed [qte_pkg::ANGLE_W-1:0] step_angle;

   always_comb begin
      xs         = x_ff >>> i_ff;
      ys         = y_ff >>> i_ff;
      step_angle = qte_pkg::atan_q32(5'(i_ff));
      x_in_n     = x_ff;
      y_in_n     = y_ff;
      z_in       = z_ff;
      i_in       = i_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (start) begin
         // A zero vector has angle zero; a vector in the left half is first turned by pi.
         i_in = '0;
         if (x_in == '0 && y_in == '0) begin
            z_in    = '0;
            done_in = 1'b1;
         end else if (x_in < 0) begin
            x_in_n = -x_in;
            y_in_n = -y_in;
            z_in   = (y_in >= 0) ? qte_pkg::PI_Q32 : -qte_pkg::PI_Q32;
            run_in = 1'b1;
         end else begin
            x_in_n = x_in;
            y_in_n = y_in;
            z_in   = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         // Rotate towards the x axis and accumulate the turned angle.
         if (y_ff >= 0) begin
            x_in_n = x_ff + ys;
            y_in_n = y_ff - xs;
            z_in   = z_ff + step_angle;
         end else begin
            x_in_n = x_ff - ys;
            y_in_n = y_ff + xs;
            z_in   = z_ff - step_angle;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == qte_pkg::STEP_W'(qte_pkg::CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      x_ff <= x_in_n;
      y_ff <= y_in_n;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

### rtl/quaternion_to_euler_with_gravity_unit.sv
// Channel   Handshake                 Payload
// req       req_valid / req_stall     quaternion, accelerometer, gyroscope
// rsp       rsp_valid / rsp_stall     roll, pitch, yaw, gauges, gravity
// csr       csr_wr_en                 still_threshold
//
// A response is loaded once the request has gone through the shared multiplier
// for its products, the drain, sum and pitch-square steps that combine terms,
// the pitch cosine root, the three CORDIC angles (a zero vector finishes its
// angle early) and, when gravity is latched, the gravity root. The next
// request can be accepted in the cycle after the response is loaded. A
// finished response waits in the output register while the next request is
// accepted; a stalled response holds the sequencer at the end.
// Synchronous reset clears the sequencer, the threshold (to 3) and gravity.
module quaternion_to_euler_with_gravity_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_quat_w,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [15:0]  req_gyro_x,
   input  logic signed [15:0]  req_gyro_y,
   input  logic signed [15:0]  req_gyro_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [14:0]  rsp_roll_angle,
   output logic signed [13:0]  rsp_pitch_angle,
   output logic signed [14:0]  rsp_yaw_angle,
   output logic [4:0]          rsp_roll_gauge,
   output logic [4:0]          rsp_pitch_gauge,
   output logic [4:0]          rsp_yaw_gauge,
   output logic [15:0]         rsp_gravity_level,
   output logic                rsp_gravity_updated,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   localparam int NPROD = 16;

   // Round half away from zero from Q.32 to Q3.12, then clamp to the limit.
   function automatic logic signed [15:0] to_q12(input logic signed [35:0] a,
                                                 input logic [15:0] lim);
      logic signed [35:0] mag;
      logic signed [16:0] r;
      logic signed [16:0] l;
      mag = (a >= 0) ? a : -a;
      r   = 17'((mag + 36'sd524288) >>> 20);
      if (a < 0) begin
         r = -r;
      end
      l = $signed({1'b0, lim});
      if (r > l) begin
         r = l;
      end
      if (r < -l) begin
         r = -l;
      end
      return r[15:0];
   endfunction

   // Bar length 0..18: counts the eighteenths of the full range reached.
   function automatic logic [4:0] gauge(input logic signed [15:0] r,
                                        input logic [15:0] lim);
      logic [16:0] v;
      logic [21:0] v18;
      logic [4:0]  n;
      v   = 17'($signed({r[15], r}) + $signed({1'b0, lim}));
      v18 = 22'(v) * 22'd18;
      n   = '0;
      for (int k = 1; k <= 18; k++) begin
         if (v18 >= 22'(k) * 22'({lim, 1'b0})) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

   qte_pkg::seq_state_type state_ff, state_in;

   logic [15:0]        thr_ff;
   logic [15:0]        hold_ff, hold_in;
   logic               upd_ff;
   logic [3:0]         cnt_ff;
   logic               launched_ff, launched_in;

   // Request fields held for the duration of the work.
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] gx_ff, gy_ff, gz_ff;

   // Shared multiplier.
   logic signed [29:0] mul_a, mul_b;
   logic signed [59:0] prod_ff;
   logic [3:0]         widx_ff;
   logic               wen_ff;
   logic signed [33:0] p_ff [NPROD];

   // Combined terms.
   logic signed [35:0] ry_ff, rx_ff, yy_ff, yx_ff;
   logic signed [29:0] ps_ff;
   logic [33:0]        asq_ff;
   logic               still_ff;
   logic [28:0]        pc_ff;
   logic signed [35:0] ps_raw;
   logic [33:0]        gsq;

   // Angles.
   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;

   // Unit hookup.
   logic                      sq_start, sq_done;
   logic [qte_pkg::RAD_W-1:0] sq_rad;
   logic [28:0]               sq_root;
   logic [30:0]               sq_rem;
   logic                      cd_start, cd_done;
   logic signed [39:0]        cd_y, cd_x;
   logic signed [35:0]        cd_angle;
   logic [16:0]               mag;

   logic accept;
   logic load_rsp;
   logic rsp_valid_ff, rsp_valid_in;

   logic [4:0]         roll_g_ff, pitch_g_ff, yaw_g_ff;
   logic signed [14:0] roll_o_ff, yaw_o_ff;
   logic signed [13:0] pitch_o_ff;
   logic [15:0]        grav_o_ff;
   logic               upd_o_ff;

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .start     (sq_start),
      .radicand  (sq_rad),
      .done      (sq_done),
      .root      (sq_root),
      .remainder (sq_rem)
   );

   qte_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cd_start),
      .y_in  (cd_y),
      .x_in  (cd_x),
      .done  (cd_done),
      .angle (cd_angle)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qte_pkg::ST_IDLE:   if (req_valid) state_in = qte_pkg::ST_MUL;
         qte_pkg::ST_MUL:    if (cnt_ff == 4'(NPROD - 1)) state_in = qte_pkg::ST_DRAIN;
         qte_pkg::ST_DRAIN:  state_in = qte_pkg::ST_SUM;
         qte_pkg::ST_SUM:    state_in = qte_pkg::ST_PSQ;
         qte_pkg::ST_PSQ:    state_in = qte_pkg::ST_PCROOT;
         qte_pkg::ST_PCROOT: if (sq_done) state_in = qte_pkg::ST_ROLL;
         qte_pkg::ST_ROLL:   if (cd_done) state_in = qte_pkg::ST_PITCH;
         qte_pkg::ST_PITCH:  if (cd_done) state_in = qte_pkg::ST_YAW;
         qte_pkg::ST_YAW: begin
            if (cd_done) begin
               state_in = still_ff ? qte_pkg::ST_GRAV : qte_pkg::ST_DONE;
            end
         end
         qte_pkg::ST_GRAV:   if (sq_done) state_in = qte_pkg::ST_DONE;
         qte_pkg::ST_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = qte_pkg::ST_IDLE;
         default:            state_in = qte_pkg::ST_IDLE;
      endcase
   end

   // Control strobes of the sequencer.
   always_comb begin
      req_stall = (state_ff != qte_pkg::ST_IDLE);
      accept    = req_valid && (state_ff == qte_pkg::ST_IDLE);
      sq_start  = !launched_ff &&
                  (state_ff == qte_pkg::ST_PCROOT || state_ff == qte_pkg::ST_GRAV);
      cd_start  = !launched_ff &&
                  (state_ff == qte_pkg::ST_ROLL || state_ff == qte_pkg::ST_PITCH ||
                   state_ff == qte_pkg::ST_YAW);
      load_rsp  = (state_ff == qte_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      launched_in = (launched_ff || sq_start || cd_start) && !(sq_done || cd_done);
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == qte_pkg::ST_PSQ) begin
         mul_a = ps_ff;
         mul_b = ps_ff;
      end else begin
         case (cnt_ff)
            4'd0:    begin mul_a = 30'(qw_ff); mul_b = 30'(qx_ff); end
            4'd1:    begin mul_a = 30'(qy_ff); mul_b = 30'(qz_ff); end
            4'd2:    begin mul_a = 30'(qx_ff); mul_b = 30'(qx_ff); end
            4'd3:    begin mul_a = 30'(qy_ff); mul_b = 30'(qy_ff); end
            4'd4:    begin mul_a = 30'(qw_ff); mul_b = 30'(qy_ff); end
            4'd5:    begin mul_a = 30'(qz_ff); mul_b = 30'(qx_ff); end
            4'd6:    begin mul_a = 30'(qw_ff); mul_b = 30'(qz_ff); end
            4'd7:    begin mul_a = 30'(qx_ff); mul_b = 30'(qy_ff); end
            4'd8:    begin mul_a = 30'(qz_ff); mul_b = 30'(qz_ff); end
            4'd9:    begin mul_a = 30'(gx_ff); mul_b = 30'(gx_ff); end
            4'd10:   begin mul_a = 30'(gy_ff); mul_b = 30'(gy_ff); end
            4'd11:   begin mul_a = 30'(gz_ff); mul_b = 30'(gz_ff); end
            4'd12:   begin mul_a = 30'(ax_ff); mul_b = 30'(ax_ff); end
            4'd13:   begin mul_a = 30'(ay_ff); mul_b = 30'(ay_ff); end
            4'd14:   begin mul_a = 30'(az_ff); mul_b = 30'(az_ff); end
            default: begin
               mul_a = $signed({14'd0, thr_ff});
               mul_b = $signed({14'd0, thr_ff});
            end
         endcase
      end
   end

   // Raw asin argument and the sum of gyro squares for the stillness test.
   always_comb begin
      ps_raw = (36'(p_ff[4]) - 36'(p_ff[5])) <<< 1;
      gsq    = 34'(p_ff[9][31:0]) + 34'(p_ff[10][31:0]) + 34'(p_ff[11][31:0]);
   end

   // Square root and CORDIC operand selection, and the rounded gravity magnitude.
   always_comb begin
      if (state_ff == qte_pkg::ST_PCROOT) begin
         sq_rad = (58'd1 << 56) - 58'(prod_ff[56:0]);
      end else begin
         sq_rad = 58'(asq_ff);
      end
      case (state_ff)
         qte_pkg::ST_PITCH: begin
            cd_y = 40'(ps_ff);
            cd_x = $signed({11'd0, pc_ff});
         end
         qte_pkg::ST_YAW: begin
            cd_y = 40'(yy_ff);
            cd_x = 40'(yx_ff);
         end
         default: begin
            cd_y = 40'(ry_ff);
            cd_x = 40'(rx_ff);
         end
      endcase
      mag     = 17'(sq_root) + ((sq_rem > 31'(sq_root)) ? 17'd1 : 17'd0);
      hold_in = mag[16] ? 16'hFFFF : mag[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qte_pkg::ST_IDLE;
         thr_ff       <= qte_pkg::STILL_RESET;
         hold_ff      <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         wen_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         wen_ff       <= (state_ff == qte_pkg::ST_MUL);
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (state_ff == qte_pkg::ST_MUL) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
         if (state_ff == qte_pkg::ST_GRAV && sq_done) begin
            hold_ff <= hold_in;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         qw_ff <= req_quat_w;
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gx_ff <= req_gyro_x;
         gy_ff <= req_gyro_y;
         gz_ff <= req_gyro_z;
      end
      prod_ff <= mul_a * mul_b;
      widx_ff <= cnt_ff;
      if (wen_ff) begin
         p_ff[widx_ff] <= prod_ff[33:0];
      end
      if (state_ff == qte_pkg::ST_SUM) begin
         ry_ff  <= (36'(p_ff[0]) + 36'(p_ff[1])) <<< 1;
         rx_ff  <= 36'sd268435456 - ((36'(p_ff[2]) + 36'(p_ff[3])) <<< 1);
         yy_ff  <= (36'(p_ff[6]) + 36'(p_ff[7])) <<< 1;
         yx_ff  <= 36'sd268435456 - ((36'(p_ff[3]) + 36'(p_ff[8])) <<< 1);
         if (ps_raw > 36'sd268435456) begin
            ps_ff <= 30'sd268435456;
         end else if (ps_raw < -36'sd268435456) begin
            ps_ff <= -30'sd268435456;
         end else begin
            ps_ff <= ps_raw[29:0];
         end
         asq_ff   <= 34'(p_ff[12][31:0]) + 34'(p_ff[13][31:0]) + 34'(p_ff[14][31:0]);
         still_ff <= (gsq <= 34'(p_ff[15][32:0]));
      end
      if (state_ff == qte_pkg::ST_PCROOT && sq_done) begin
         pc_ff <= sq_root;
      end
      if (cd_done) begin
         case (state_ff)
            qte_pkg::ST_ROLL:  roll_ff  <= to_q12(cd_angle, qte_pkg::PI_Q12);
            qte_pkg::ST_PITCH: pitch_ff <= to_q12(cd_angle, qte_pkg::HPI_Q12);
            qte_pkg::ST_YAW:   yaw_ff   <= to_q12(cd_angle, qte_pkg::PI_Q12);
            default:           roll_ff  <= roll_ff;
         endcase
      end
      if (state_ff == qte_pkg::ST_YAW && cd_done) begin
         upd_ff <= still_ff;
      end
      // Response register.
      if (load_rsp) begin
         roll_o_ff  <= roll_ff[14:0];
         pitch_o_ff <= pitch_ff[13:0];
         yaw_o_ff   <= yaw_ff[14:0];
         roll_g_ff  <= gauge(roll_ff, qte_pkg::PI_Q12);
         pitch_g_ff <= gauge(pitch_ff, qte_pkg::HPI_Q12);
         yaw_g_ff   <= gauge(yaw_ff, qte_pkg::PI_Q12);
         grav_o_ff  <= hold_ff;
         upd_o_ff   <= upd_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_roll_angle      = roll_o_ff;
   assign rsp_pitch_angle     = pitch_o_ff;
   assign rsp_yaw_angle       = yaw_o_ff;
   assign rsp_roll_gauge      = roll_g_ff;
   assign rsp_pitch_gauge     = pitch_g_ff;
   assign rsp_yaw_gauge       = yaw_g_ff;
   assign rsp_gravity_level   = grav_o_ff;
   assign rsp_gravity_updated = upd_o_ff;

endmodule

### tb/quaternion_to_euler_with_gravity_unit_tb.sv
module quaternion_to_euler_with_gravity_unit_tb;

   typedef struct packed {
      logic signed [15:0] qw;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic signed [15:0] gz;
   } orient_req_type;

   typedef struct packed {
      logic signed [14:0] roll;
      logic signed [13:0] pitch;
      logic signed [14:0] yaw;
      logic [4:0]         roll_g;
      logic [4:0]         pitch_g;
      logic [4:0]         yaw_g;
      logic [15:0]        grav;
      logic               grav_upd;
   } orient_rsp_type;

   // One directed row: the request, and a typed-in response where it is obvious.
   typedef struct packed {
      orient_req_type req;
      logic           typed;
      orient_rsp_type rsp;
   } orient_row_type;

   localparam longint ONE_Q28  = 64'sd1 << 28;
   localparam longint PI_L     = 64'sd13493037705;
   localparam int     LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   orient_req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   orient_rsp_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   // Typed-in expectation travelling with the directed request.
   logic           row_typed = 1'b0;
   orient_rsp_type row_rsp = '0;

   orient_rsp_type expected_rsp_q[$];
   int          mismatch_count = 0;
   logic [15:0] still_thr_model;
   logic [15:0] gravity_model;
   longint      atan_tab[0:qte_pkg::CORDIC_STEPS-1];
   logic        quiet_tail = 1'b0;
   logic        long_hold_now = 1'b0;

   always #1 clock = ~clock;

   quaternion_to_euler_with_gravity_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_quat_w(req_item.qw),
      .req_quat_x(req_item.qx),
      .req_quat_y(req_item.qy),
      .req_quat_z(req_item.qz),
      .req_accel_x(req_item.ax),
      .req_accel_y(req_item.ay),
      .req_accel_z(req_item.az),
      .req_gyro_x(req_item.gx),
      .req_gyro_y(req_item.gy),
      .req_gyro_z(req_item.gz),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_roll_angle(rsp_item.roll),
      .rsp_pitch_angle(rsp_item.pitch),
      .rsp_yaw_angle(rsp_item.yaw),
      .rsp_roll_gauge(rsp_item.roll_g),
      .rsp_pitch_gauge(rsp_item.pitch_g),
      .rsp_yaw_gauge(rsp_item.yaw_g),
      .rsp_gravity_level(rsp_item.grav),
      .rsp_gravity_updated(rsp_item.grav_upd),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Arctangent of 2^-i in Q.32 radians, summed from its power series.
   function automatic longint arctan_pow2(int i);
      longint acc;
      longint t;
      int k;
      acc = 0;
      if (i == 0) begin
         return 64'sd3373259426;
      end
      for (k = 0; i * (2 * k + 1) <= 62; k++) begin
         t = (64'sd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
         acc = (k % 2 == 1) ? acc - t : acc + t;
      end
      return (acc + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic longint floor_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // CORDIC vectoring; a negative x is first turned by pi.
   function automatic longint vector_angle(longint y, longint x);
      longint z;
      longint xs;
      longint ys;
      int i;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? PI_L : -PI_L;
         x = -x;
         y = -y;
      end
      for (i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_tab[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_tab[i];
         end
      end
      return z;
   endfunction

   // Rounds Q.32 radians half away from zero to Q3.12 and clamps.
   function automatic longint angle_q12(longint a, longint lim);
      longint r;
      r = (a >= 0) ? (a + (64'sd1 << 19)) >>> 20 : -(((-a) + (64'sd1 << 19)) >>> 20);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   // Euler angles, gauges and the gravity latch for one request.
   function automatic orient_rsp_type predict_orientation(orient_req_type r);
      orient_rsp_type o;
      longint w, x, y, z, ry, rx, ps, pc, yy, yx, roll, pitch, yaw;
      longint gsq, asq, thr, mag;
      w = r.qw; x = r.qx; y = r.qy; z = r.qz;
      ry = 2 * (w * x + y * z);
      rx = ONE_Q28 - 2 * (x * x + y * y);
      ps = 2 * (w * y - z * x);
      yy = 2 * (w * z + x * y);
      yx = ONE_Q28 - 2 * (y * y + z * z);
      if (ps > ONE_Q28) ps = ONE_Q28;
      if (ps < -ONE_Q28) ps = -ONE_Q28;
      pc = floor_sqrt(ONE_Q28 * ONE_Q28 - ps * ps);
      roll = angle_q12(vector_angle(ry, rx), 12868);
      pitch = angle_q12(vector_angle(ps, pc), 6434);
      yaw = angle_q12(vector_angle(yy, yx), 12868);
      gsq = longint'(r.gx) * r.gx + longint'(r.gy) * r.gy + longint'(r.gz) * r.gz;
      thr = still_thr_model;
      o.grav_upd = 1'b0;
      if (gsq <= thr * thr) begin
         asq = longint'(r.ax) * r.ax + longint'(r.ay) * r.ay + longint'(r.az) * r.az;
         mag = floor_sqrt(asq);
         if (asq - mag * mag > mag) mag++;
         if (mag > 65535) mag = 65535;
         gravity_model = mag[15:0];
         o.grav_upd = 1'b1;
      end
      o.roll = roll[14:0];
      o.pitch = pitch[13:0];
      o.yaw = yaw[14:0];
      o.roll_g = 5'((roll + 12868) * 18 / 25736);
      o.pitch_g = 5'((pitch + 6434) * 18 / 12868);
      o.yaw_g = 5'((yaw + 12868) * 18 / 25736);
      o.grav = gravity_model;
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      mismatch_count++;
   endtask

   // Request acceptance feeds the predictor; response acceptance is checked.
   always @(posedge clock) begin
      orient_rsp_type e;
      if (reset) begin
         still_thr_model = qte_pkg::STILL_RESET;
         gravity_model = 16'd0;
      end else begin
         if (csr_wr_en) begin
            still_thr_model = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            e = predict_orientation(req_item);
            if (row_typed) e = row_rsp;
            expected_rsp_q = {expected_rsp_q, e};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no request outstanding", 1, 0);
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_item.roll !== e.roll) report_mismatch("roll", rsp_item.roll, e.roll);
               if (rsp_item.pitch !== e.pitch)
                  report_mismatch("pitch", rsp_item.pitch, e.pitch);
               if (rsp_item.yaw !== e.yaw) report_mismatch("yaw", rsp_item.yaw, e.yaw);
               if (rsp_item.roll_g !== e.roll_g)
                  report_mismatch("roll_gauge", rsp_item.roll_g, e.roll_g);
               if (rsp_item.pitch_g !== e.pitch_g)
                  report_mismatch("pitch_gauge", rsp_item.pitch_g, e.pitch_g);
               if (rsp_item.yaw_g !== e.yaw_g)
                  report_mismatch("yaw_gauge", rsp_item.yaw_g, e.yaw_g);
               if (rsp_item.grav !== e.grav)
                  report_mismatch("gravity_level", rsp_item.grav, e.grav);
               if (rsp_item.grav_upd !== e.grav_upd)
                  report_mismatch("gravity_updated", rsp_item.grav_upd, e.grav_upd);
            end
         end
      end
   end

   // Receiver: random stall bursts, one long hold on request, none at the end.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (long_hold_now) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            wait (!long_hold_now);
         end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
            rsp_stall <= 1'b0;
            if (!quiet_tail) repeat ($urandom_range(0, 12)) @(posedge clock);
         end else begin
            n = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request, with an optional idle burst first, until accepted.
   task automatic offer_request(orient_req_type r, logic typed, orient_rsp_type rsp);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      row_typed <= typed;
      row_rsp <= rsp;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      drain_responses();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [15:0] quat_part();
      logic signed [15:0] picks[7] = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd11585,
                                       -16'sd11585, 16'sd8192, -16'sd8192};
      if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 6)];
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic logic signed [15:0] gyro_part(int mode, int lim);
      if (mode == 0) return 16'($signed($urandom_range(0, 8)) - 4);
      if (mode == 1) return 16'($signed($urandom_range(0, lim)) - lim / 2);
      return 16'($urandom());
   endfunction

   // Random request: each quaternion part unit-like or arbitrary; gyro small, scaled to the threshold, or arbitrary.
   function automatic orient_req_type random_request(int thr);
      orient_req_type r;
      int mode;
      r.qw = quat_part(); r.qx = quat_part(); r.qy = quat_part(); r.qz = quat_part();
      if ($urandom_range(0, 1) == 0) begin
         r.ax = 16'($signed($urandom_range(0, 600)) - 300);
         r.ay = 16'($signed($urandom_range(0, 600)) - 300);
         r.az = 16'($signed($urandom_range(0, 4096)) - 2048);
      end else begin
         r.ax = 16'($urandom()); r.ay = 16'($urandom()); r.az = 16'($urandom());
      end
      mode = $urandom_range(0, 2);
      r.gx = gyro_part(mode, thr); r.gy = gyro_part(mode, thr); r.gz = gyro_part(mode, thr);
      return r;
   endfunction

   initial begin
      orient_row_type rows[$];
      orient_row_type row;
      int thr_list[4];
      int p;
      int i;
      for (i = 0; i < qte_pkg::CORDIC_STEPS; i++) atan_tab[i] = arctan_pow2(i);

      // Directed rows: identity and zero quaternion, saturated pitch, turned-by-pi
      // roll and yaw, extreme accelerometer and gyro, threshold equality.
      row = '0;
      row.req = '{16384, 0, 0, 0, 0, 0, 2048, 0, 0, 0};
      row.typed = 1'b1;
      row.rsp = '{0, 0, 0, 9, 9, 9, 2048, 1'b1};
      rows = {rows, row};
      row.req = '{0, 0, 0, 0, -32768, -32768, -32768, 0, 0, 0};
      row.rsp = '{0, 0, 0, 9, 9, 9, 56756, 1'b1};
      rows = {rows, row};
      row.req = '{16384, 0, 0, 0, 32767, 32767, 32767, 32767, -32768, 32767};
      row.rsp = '{0, 0, 0, 9, 9, 9, 56756, 1'b0};
      rows = {rows, row};
      row.req = '{16384, 0, 0, 0, 2048, 0, 0, 3, 0, 0};
      row.rsp = '{0, 0, 0, 9, 9, 9, 2048, 1'b1};
      rows = {rows, row};
      row.req = '{16384, 0, 0, 0, 0, 2048, 0, 3, 1, 0};
      row.rsp = '{0, 0, 0, 9, 9, 9, 2048, 1'b0};
      rows = {rows, row};
      row.typed = 1'b0;
      row.req = '{0, 16384, 0, 0, 0, 0, 2048, 0, 0, 0};
      rows = {rows, row};
      row.req = '{16384, 0, 16384, 0, 0, 0, 0, -2, 2, 0};
      rows = {rows, row};
      row.req = '{-16384, 0, 16384, 0, 100, -100, 0, 0, 0, 0};
      rows = {rows, row};
      row.req = '{0, 0, 0, 16384, 0, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.req = '{0, 0, 16384, 0, 1, 1, 1, 0, 0, 0};
      rows = {rows, row};
      row.req = '{11585, -11585, 0, 0, 0, 0, 2048, 0, 0, 0};
      rows = {rows, row};
      row.req = '{11585, 0, 0, -11585, -2048, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.req = '{16384, 16384, 16384, 16384, 0, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.req = '{-16384, -16384, -16384, -16384, 1, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.req = '{8192, -8192, 8192, -8192, 0, 0, 0, -32768, -32768, -32768};
      rows = {rows, row};
      row.req = '{0, 16384, 16384, 0, 0, 0, 0, 0, 0, 0};
      rows = {rows, row};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_threshold(16'd3);
      foreach (rows[k]) offer_request(rows[k].req, rows[k].typed, rows[k].rsp);

      // Random phases, each under its own threshold, extremes included.
      thr_list = '{65535, 0, $urandom_range(1, 2000), $urandom_range(0, 65535)};
      for (p = 0; p < 4; p++) begin
         write_threshold(16'(thr_list[p]));
         for (i = 0; i < 200; i++) begin
            if (p == 1 && i == 50) long_hold_now <= 1'b1;
            if (p == 1 && i == 60) long_hold_now <= 1'b0;
            if (p == 2 && i == 100) drain_responses();
            if (p == 3 && i == 100) quiet_tail <= 1'b1;
            offer_request(random_request(thr_list[p]), 1'b0, '0);
         end
      end
      drain_responses();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
